[rtl/poua_pkg.sv]
// ----------------------------------------------------------------------------
// poua_pkg
// Shared types and codes for the per-owner usage aggregator: request codes,
// transfer payloads, table entry layout, controller states, and the command
// and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package poua_pkg;

   localparam int OWNER_W = 32;
   localparam int BYTES_W = 63;
   localparam int COUNT_W = 31;

   typedef enum logic [1:0] {
      REQ_RECORD = 2'd0,
      REQ_REPORT = 2'd1,
      REQ_CLEAR  = 2'd2
   } req_code_type;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [OWNER_W-1:0] owner_id;
      logic [BYTES_W-1:0] file_size;
   } req_item_type;

   typedef struct packed {
      logic [OWNER_W-1:0] owner_id_out;
      logic [BYTES_W-1:0] total_bytes;
      logic [COUNT_W-1:0] file_count;
      logic               entry_valid;
      logic               table_overflow;
      logic               last;
   } rsp_item_type;

   typedef struct packed {
      logic [OWNER_W-1:0] owner_id;
      logic [BYTES_W-1:0] total_bytes;
      logic [COUNT_W-1:0] file_count;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP_READ,
      ST_LOOKUP_CMP,
      ST_INSERT,
      ST_SCAN_READ,
      ST_SCAN_CMP,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load_req;
      logic idx_clear;
      logic idx_inc;
      logic mem_read;
      logic write_update;
      logic write_insert;
      logic table_clear;
      logic set_overflow;
      logic scan_start;
      logic scan_eval;
      logic report_start;
      logic emit_entry;
      logic emit_empty;
   } cmd_type;

   typedef struct packed {
      logic table_empty;
      logic table_full;
      logic idx_at_end;
      logic owner_match;
      logic last_emit;
   } status_type;

endpackage

[rtl/poua_ctrl.sv]
// ----------------------------------------------------------------------------
// poua_ctrl
// Sequencer for the aggregator: runs the table lookup for record requests
// and the repeated maximum scans that order a report.
// ----------------------------------------------------------------------------
module poua_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [1:0]           req_code,
   input  poua_pkg::status_type status,
   output poua_pkg::cmd_type    cmd,
   output logic                 busy
);

   poua_pkg::state_type state_ff;
   poua_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= poua_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         poua_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               case (req_code)
                  poua_pkg::REQ_RECORD: begin
                     cmd.load_req  = 1'b1;
                     cmd.idx_clear = 1'b1;
                     state_in = status.table_empty ? poua_pkg::ST_INSERT
                                                   : poua_pkg::ST_LOOKUP_READ;
                  end
                  poua_pkg::REQ_REPORT: begin
                     if (status.table_empty) begin
                        cmd.emit_empty = 1'b1;
                     end else begin
                        cmd.report_start = 1'b1;
                        cmd.idx_clear    = 1'b1;
                        cmd.scan_start   = 1'b1;
                        state_in = poua_pkg::ST_SCAN_READ;
                     end
                  end
                  poua_pkg::REQ_CLEAR: begin
                     cmd.table_clear = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         poua_pkg::ST_LOOKUP_READ: begin
            cmd.mem_read = 1'b1;
            state_in = poua_pkg::ST_LOOKUP_CMP;
         end
         poua_pkg::ST_LOOKUP_CMP: begin
            if (status.owner_match) begin
               cmd.write_update = 1'b1;
               state_in = poua_pkg::ST_IDLE;
            end else if (status.idx_at_end) begin
               state_in = poua_pkg::ST_INSERT;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in = poua_pkg::ST_LOOKUP_READ;
            end
         end
         poua_pkg::ST_INSERT: begin
            if (status.table_full) begin
               cmd.set_overflow = 1'b1;
            end else begin
               cmd.write_insert = 1'b1;
            end
            state_in = poua_pkg::ST_IDLE;
         end
         poua_pkg::ST_SCAN_READ: begin
            cmd.mem_read = 1'b1;
            state_in = poua_pkg::ST_SCAN_CMP;
         end
         poua_pkg::ST_SCAN_CMP: begin
            cmd.scan_eval = 1'b1;
            if (status.idx_at_end) begin
               state_in = poua_pkg::ST_EMIT;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in = poua_pkg::ST_SCAN_READ;
            end
         end
         poua_pkg::ST_EMIT: begin
            cmd.emit_entry = 1'b1;
            if (status.last_emit) begin
               state_in = poua_pkg::ST_IDLE;
            end else begin
               cmd.idx_clear  = 1'b1;
               cmd.scan_start = 1'b1;
               state_in = poua_pkg::ST_SCAN_READ;
            end
         end
         default: begin
            state_in = poua_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

[rtl/poua_datapath.sv]
// ----------------------------------------------------------------------------
// poua_datapath
// Table memory, entry count, overflow flag, saturating update arithmetic,
// the running maximum of a report scan, and the result register.
// ----------------------------------------------------------------------------
module poua_datapath #(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  poua_pkg::req_item_type req_data,
   input  poua_pkg::cmd_type      cmd,
   output poua_pkg::status_type   status,
   output logic                   rsp_strobe,
   output poua_pkg::rsp_item_type rsp_data
);

   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   poua_pkg::entry_type mem [TABLE_ENTRIES];
   poua_pkg::entry_type rd_ff;

   logic [poua_pkg::OWNER_W-1:0] owner_ff;
   logic [poua_pkg::BYTES_W-1:0] size_ff;
   logic [IDX_W-1:0]             idx_ff;
   logic [CNT_W-1:0]             count_ff;
   logic [CNT_W-1:0]             emitted_ff;
   logic                         overflow_ff;

   poua_pkg::entry_type          best_ff;
   logic [IDX_W-1:0]             best_idx_ff;
   logic                         best_valid_ff;
   logic [poua_pkg::BYTES_W-1:0] prev_total_ff;
   logic [IDX_W-1:0]             prev_idx_ff;
   logic                         have_prev_ff;

   logic                         rsp_strobe_ff;
   poua_pkg::rsp_item_type       rsp_data_ff;

   logic [poua_pkg::BYTES_W:0]   sum;
   poua_pkg::entry_type          upd_entry;
   poua_pkg::entry_type          new_entry;
   logic                         eligible;
   logic                         take;

   // Saturating accumulate of the entry just read.
   always_comb begin
      sum = {1'b0, rd_ff.total_bytes} + {1'b0, size_ff};
      upd_entry.owner_id    = rd_ff.owner_id;
      upd_entry.total_bytes = sum[poua_pkg::BYTES_W] ? '1 : sum[poua_pkg::BYTES_W-1:0];
      upd_entry.file_count  = (rd_ff.file_count == '1) ? rd_ff.file_count
                                                       : rd_ff.file_count + 1'b1;
      new_entry.owner_id    = owner_ff;
      new_entry.total_bytes = size_ff;
      new_entry.file_count  = poua_pkg::COUNT_W'(1);
   end

   // An entry is still to be reported if it sorts after the previous output.
   // Strict greater-than keeps the lowest index among equal totals.
   always_comb begin
      eligible = !have_prev_ff
                 || (rd_ff.total_bytes < prev_total_ff)
                 || ((rd_ff.total_bytes == prev_total_ff) && (idx_ff > prev_idx_ff));
      take     = eligible && (!best_valid_ff || (rd_ff.total_bytes > best_ff.total_bytes));
   end

   always_comb begin
      status.table_empty = (count_ff == '0);
      status.table_full  = (count_ff == CNT_W'(TABLE_ENTRIES));
      status.idx_at_end  = ((CNT_W'(idx_ff) + 1'b1) == count_ff);
      status.owner_match = (rd_ff.owner_id == owner_ff);
      status.last_emit   = ((emitted_ff + 1'b1) == count_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.write_update) begin
         mem[idx_ff] <= upd_entry;
      end else if (cmd.write_insert) begin
         mem[count_ff[IDX_W-1:0]] <= new_entry;
      end
      if (cmd.mem_read) begin
         rd_ff <= mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         count_ff      <= '0;
         emitted_ff    <= '0;
         overflow_ff   <= 1'b0;
         best_valid_ff <= 1'b0;
         have_prev_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (cmd.idx_clear) begin
            idx_ff <= '0;
         end else if (cmd.idx_inc) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (cmd.table_clear) begin
            count_ff    <= '0;
            overflow_ff <= 1'b0;
         end else begin
            if (cmd.write_insert) begin
               count_ff <= count_ff + 1'b1;
            end
            if (cmd.set_overflow) begin
               overflow_ff <= 1'b1;
            end
         end
         if (cmd.report_start) begin
            emitted_ff   <= '0;
            have_prev_ff <= 1'b0;
         end else if (cmd.emit_entry) begin
            emitted_ff   <= emitted_ff + 1'b1;
            have_prev_ff <= 1'b1;
         end
         if (cmd.scan_start) begin
            best_valid_ff <= 1'b0;
         end else if (cmd.scan_eval && take) begin
            best_valid_ff <= 1'b1;
         end
         rsp_strobe_ff <= cmd.emit_entry | cmd.emit_empty;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         owner_ff <= req_data.owner_id;
         size_ff  <= req_data.file_size;
      end
      if (cmd.scan_eval && take) begin
         best_ff     <= rd_ff;
         best_idx_ff <= idx_ff;
      end
      if (cmd.emit_entry) begin
         prev_total_ff <= best_ff.total_bytes;
         prev_idx_ff   <= best_idx_ff;
      end
      if (cmd.emit_entry) begin
         rsp_data_ff.owner_id_out   <= best_ff.owner_id;
         rsp_data_ff.total_bytes    <= best_ff.total_bytes;
         rsp_data_ff.file_count     <= best_ff.file_count;
         rsp_data_ff.entry_valid    <= 1'b1;
         rsp_data_ff.table_overflow <= overflow_ff;
         rsp_data_ff.last           <= status.last_emit;
      end else if (cmd.emit_empty) begin
         rsp_data_ff.owner_id_out   <= '0;
         rsp_data_ff.total_bytes    <= '0;
         rsp_data_ff.file_count     <= '0;
         rsp_data_ff.entry_valid    <= 1'b0;
         rsp_data_ff.table_overflow <= overflow_ff;
         rsp_data_ff.last           <= 1'b1;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

[rtl/per_owner_usage_aggregator_unit.sv]
// ----------------------------------------------------------------------------
// per_owner_usage_aggregator_unit
// Keyed group-by-sum table: per-owner byte totals and file counts, with a
// report sorted by byte total, largest first.
// ----------------------------------------------------------------------------
// A request is transferred at a rising edge where start is high and busy is
// low; busy stays high until the request is finished. Results come out on
// rsp_data with rsp_strobe high for exactly one cycle each, and the receiver
// has no way to hold them off, so it must take every strobed result.
//
// Request handling:
//   Clear, and the unused request code: busy does not rise after the transfer.
//   Record: each table entry compared takes a memory read state and then a
//   compare state, stopping at a hit; a new owner or a drop on a full
//   table goes on through every entry in the table and then to the insert
//   state. The single read port of the table memory sets this pace.
//   Report: each result costs one full scan of the table plus one emit
//   state to issue it. The report on an empty table is one result,
//   strobed the cycle after the transfer, with busy staying low.
//
// The report order is found without moving any entry: each scan picks the
// largest total that sorts after the previously issued entry, with equal
// totals taken in insertion order. The table_overflow flag is sticky until
// a clear request and rides on every result of a report. Table contents
// beyond the entry count are never read, so the memory needs no clearing
// after reset.
// ----------------------------------------------------------------------------
module per_owner_usage_aggregator_unit #(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  poua_pkg::req_item_type req_data,
   output logic                   rsp_strobe,
   output poua_pkg::rsp_item_type rsp_data
);

   poua_pkg::cmd_type    cmd;
   poua_pkg::status_type status;

   // The controller sequences lookups and report scans.
   poua_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_code (req_data.req_type),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   // The datapath holds the table, the counters and the result register.
   poua_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
